>>> design/pis_pkg.sv
package pis_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // limit angle and tolerance widths are fixed by the item format
    localparam int ANGLE_W = 24;
    localparam int TOL_W   = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

endpackage

>>> design/pis_if.sv
interface pis_item_if
    import pis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         line_vertical;
    logic signed [COORD_BITS-1:0] line_slope;
    logic signed [COORD_BITS-1:0] line_intercept;
    logic signed [COORD_BITS-1:0] apex_x;
    logic signed [COORD_BITS-1:0] apex_y;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic        [ANGLE_W-1:0]    limit_angle;
    logic signed [COORD_BITS-1:0] limit_tangent;

    modport source (
        output valid, line_vertical, line_slope, line_intercept, apex_x, apex_y,
               dir_x, dir_y, point_x, point_y, limit_angle, limit_tangent,
        input  ready
    );
    modport sink (
        input  valid, line_vertical, line_slope, line_intercept, apex_x, apex_y,
               dir_x, dir_y, point_x, point_y, limit_angle, limit_tangent,
        output ready
    );
endinterface

interface pis_result_if
    import pis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         in_sector;
    logic                         result_kind;
    logic signed [COORD_BITS-1:0] result_value;

    modport source (output valid, in_sector, result_kind, result_value, input ready);
    modport sink   (input valid, in_sector, result_kind, result_value, output ready);
endinterface

interface pis_cfg_if
    import pis_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/pis_mul.sv
module pis_mul
    import pis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  logic        [SIDE_W-1:0]     i_side,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_prod,
    output logic        [SIDE_W-1:0]     o_side
);
    localparam int C  = COORD_BITS;
    localparam int H  = C / 2;
    localparam int HH = C - H;

    localparam logic [C-1:0] MAX_C = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] MIN_C = {1'b1, {(C-1){1'b0}}};

    logic [C-1:0]    ua, ub;
    logic [C+H-1:0]  r_plo;
    logic [C+HH-1:0] r_phi;
    logic            r_neg0, r_neg1, r_v0, r_v1, r_v2;
    logic [SIDE_W-1:0] r_sd0, r_sd1, r_sd2;
    logic [2*C-1:0]  r_full;
    logic [2*C-1:0]  n_full;
    logic [2*C-1:0]  shifted;
    logic            big;
    logic [C-1:0]    n_prod;
    logic [C-1:0]    r_prod;

    always_comb begin
        ua = i_a[C-1] ? (~i_a + 1'b1) : i_a;
        ub = i_b[C-1] ? (~i_b + 1'b1) : i_b;
    end

    // two partial products, summed in the next stage
    always_comb begin
        n_full = (2*C)'(r_plo) + {r_phi, {H{1'b0}}};
    end

    always_comb begin
        shifted = r_full >> FRAC_BITS;
        big     = |shifted[2*C-1:C-1];
        if (r_neg1) begin
            n_prod = big ? MIN_C : (~shifted[C-1:0] + 1'b1);
        end else begin
            n_prod = big ? MAX_C : shifted[C-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo  <= ua * ub[H-1:0];
            r_phi  <= ua * ub[C-1:H];
            r_neg0 <= i_a[C-1] ^ i_b[C-1];
            r_sd0  <= i_side;
            r_full <= n_full;
            r_neg1 <= r_neg0;
            r_sd1  <= r_sd0;
            r_prod <= n_prod;
            r_sd2  <= r_sd1;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_side  = r_sd2;

endmodule

>>> design/pis_div.sv
module pis_div
    import pis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS:0]   i_num,
    input  logic signed [COORD_BITS:0]   i_den,
    input  logic        [SIDE_W-1:0]     i_side,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_quot,
    output logic        [SIDE_W-1:0]     o_side
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NQ = C + 1;
    localparam int RW = C + 2;

    localparam logic [C-1:0] MAX_C = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] MIN_C = {1'b1, {(C-1){1'b0}}};

    logic [C:0]        un, ud;
    logic              ovf0;

    logic [RW-1:0]     r_rem [0:NQ];
    logic [C:0]        r_dl  [0:NQ];
    logic [NQ-1:0]     r_q   [0:NQ];
    logic [C:0]        r_ud  [0:NQ];
    logic              r_neg [0:NQ];
    logic              r_ovf [0:NQ];
    logic              r_v   [0:NQ];
    logic [SIDE_W-1:0] r_sd  [0:NQ];

    logic              big;
    logic [C-1:0]      n_quot;
    logic [C-1:0]      r_quot;
    logic              r_ov;
    logic [SIDE_W-1:0] r_osd;

    // high part of the shifted dividend: a quotient that needs more bits saturates
    always_comb begin
        un   = i_num[C] ? (~i_num + 1'b1) : i_num;
        ud   = i_den[C] ? (~i_den + 1'b1) : i_den;
        ovf0 = {{(C+1-F){1'b0}}, un[C:C+1-F]} >= ud;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {{(RW-F){1'b0}}, un[C:C+1-F]};
            r_dl[0]  <= {un[C-F:0], {F{1'b0}}};
            r_q[0]   <= '0;
            r_ud[0]  <= ud;
            r_neg[0] <= i_num[C] ^ i_den[C];
            r_ovf[0] <= ovf0;
            r_sd[0]  <= i_side;
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= NQ; i++) begin : g_step
        logic [RW-1:0] trial;
        logic [RW-1:0] ud_ext;
        logic          take;

        always_comb begin
            trial  = {r_rem[i-1][RW-2:0], r_dl[i-1][C]};
            ud_ext = {1'b0, r_ud[i-1]};
            take   = trial >= ud_ext;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= r_v[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= take ? (trial - ud_ext) : trial;
                r_dl[i]  <= r_dl[i-1] << 1;
                r_q[i]   <= {r_q[i-1][NQ-2:0], take};
                r_ud[i]  <= r_ud[i-1];
                r_neg[i] <= r_neg[i-1];
                r_ovf[i] <= r_ovf[i-1];
                r_sd[i]  <= r_sd[i-1];
            end
        end
    end

    always_comb begin
        big = r_ovf[NQ] || (|r_q[NQ][C:C-1]);
        if (r_neg[NQ]) begin
            n_quot = big ? MIN_C : (~r_q[NQ][C-1:0] + 1'b1);
        end else begin
            n_quot = big ? MAX_C : r_q[NQ][C-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
            r_osd  <= r_sd[NQ];
        end
    end

    assign o_valid = r_ov;
    assign o_quot  = r_quot;
    assign o_side  = r_osd;

endmodule

>>> design/point_in_sector_test.sv
// channel   dir  handshake     payload
// i_cfg     in   valid/ready   equal_tolerance write data, always ready
// i_item    in   valid/ready   reference line, apex, direction, point, limits
// o_result  out  valid/ready   in_sector, result_kind, result_value
//
// one item enters per cycle while the pipeline is not frozen; the datapath holds
// two one-bit-per-stage dividers and two three-stage multipliers in series
// synchronous active-low reset clears all valid bits and sets the tolerance to 1
// a result waiting at the output is backed by a one-item skid register; the
// pipeline freezes only while that skid register is full
module point_in_sector_test
    import pis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pis_cfg_if.sink      i_cfg,
    pis_item_if.sink     i_item,
    pis_result_if.source o_result
);
    localparam int C = COORD_BITS;
    localparam int F = FRAC_BITS;

    typedef logic signed [C-1:0] t_coord;
    typedef logic signed [C:0]   t_wide;
    typedef logic signed [C+2:0] t_near;

    typedef enum logic [1:0] {
        SIDE_ON    = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef enum logic {
        KIND_ANGLE   = 1'b0,
        KIND_TANGENT = 1'b1
    } t_kind;

    typedef struct packed {
        logic               lv;
        t_coord             la;
        t_coord             lb;
        t_coord             ax;
        t_coord             ay;
        t_coord             dx;
        t_coord             dy;
        t_coord             px;
        t_coord             py;
        logic [ANGLE_W-1:0] lim;
        t_coord             t;
    } t_in;

    typedef struct packed {
        logic               lv;
        t_coord             la;
        t_coord             lb;
        t_coord             py;
        logic [ANGLE_W-1:0] lim;
        t_coord             t;
        t_wide              dyn;
        t_wide              dxn;
        logic               betw;
        logic               l2v;
        logic               v_on;
        logic               v_lt;
        logic               zf;
        logic               z_on;
        logic               z_lt;
    } t_ca;

    typedef struct packed {
        logic               lv;
        t_coord             la;
        logic [ANGLE_W-1:0] lim;
        t_coord             t;
        logic               betw;
        logic               l2v;
        logic               zf;
        t_side              side;
    } t_cb;

    typedef struct packed {
        t_cb    b;
        t_coord k2a;
        logic   kz;
    } t_cc;

    typedef struct packed {
        t_kind              kind;
        t_coord             fixed;
        logic               neg;
        logic [ANGLE_W-1:0] lim;
        t_coord             t;
    } t_cd;

    typedef struct packed {
        logic   in_sector;
        t_kind  kind;
        t_coord value;
    } t_res;

    localparam logic [C-1:0]   MAX_C   = {1'b0, {(C-1){1'b1}}};
    localparam logic [C+8:0]   MAX_W   = {10'b0, {(C-1){1'b1}}};
    localparam logic [C+8:0]   A90_W   = (C+9)'(90) << F;
    localparam logic [C+8:0]   A180_W  = (C+9)'(180) << F;
    localparam logic [C-1:0]   A90     = (A90_W > MAX_W) ? MAX_C : A90_W[C-1:0];
    localparam logic [C-1:0]   A180    = (A180_W > MAX_W) ? MAX_C : A180_W[C-1:0];
    localparam logic [C:0]     ONE_1   = (C+1)'(1) << F;
    localparam logic [C+2:0]   ONE_3   = (C+3)'(1) << F;
    localparam t_near          NEG_ONE = -ONE_3;
    localparam t_near          ZERO_3  = '0;

    function automatic t_near f_x3(input t_coord x);
        return {{3{x[C-1]}}, x};
    endfunction

    function automatic t_wide f_x1(input t_coord x);
        return {x[C-1], x};
    endfunction

    // |a - b| within tolerance
    function automatic logic f_near(input t_near a, input t_near b,
                                    input logic [TOL_W-1:0] tol);
        logic signed [C+3:0] d;
        logic [C+3:0]        m;
        d = {a[C+2], a} - {b[C+2], b};
        m = d[C+3] ? (~d + 1'b1) : d;
        return m <= {{(C+4-TOL_W){1'b0}}, tol};
    endfunction

    logic             en;
    logic [TOL_W-1:0] r_tol;

    // tolerance register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.data;
        end
    end

    // input stage
    logic r_s1_v;
    t_in  r_s1;

    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.lv  <= i_item.line_vertical;
            r_s1.la  <= i_item.line_slope;
            r_s1.lb  <= i_item.line_intercept;
            r_s1.ax  <= i_item.apex_x;
            r_s1.ay  <= i_item.apex_y;
            r_s1.dx  <= i_item.dir_x;
            r_s1.dy  <= i_item.dir_y;
            r_s1.px  <= i_item.point_x;
            r_s1.py  <= i_item.point_y;
            r_s1.lim <= i_item.limit_angle;
            r_s1.t   <= i_item.limit_tangent;
        end
    end

    // direction test and side flags that need no product
    t_ca  ca;
    logic xl, yl, xp0, yp0, xp, yp, nx, ny;

    always_comb begin
        xl  = r_s1.dx < r_s1.ax;
        yl  = r_s1.dy < r_s1.ay;
        xp0 = r_s1.px < r_s1.ax;
        yp0 = r_s1.py < r_s1.ay;
        nx  = f_near(f_x3(r_s1.px), f_x3(r_s1.ax), r_tol) ||
              f_near(f_x3(r_s1.px), f_x3(r_s1.dx), r_tol);
        ny  = f_near(f_x3(r_s1.py), f_x3(r_s1.ay), r_tol) ||
              f_near(f_x3(r_s1.py), f_x3(r_s1.dy), r_tol);
        xp  = nx ? ((yl == yp0) ? xl : !xl) : xp0;
        yp  = ny ? ((xl == xp) ? yl : !yl) : yp0;

        ca.lv   = r_s1.lv;
        ca.la   = r_s1.la;
        ca.lb   = r_s1.lb;
        ca.py   = r_s1.py;
        ca.lim  = r_s1.lim;
        ca.t    = r_s1.t;
        ca.dyn  = f_x1(r_s1.py) - f_x1(r_s1.ay);
        ca.dxn  = f_x1(r_s1.px) - f_x1(r_s1.ax);
        ca.betw = (xl == xp) || (yl == yp);
        ca.l2v  = f_near(f_x3(r_s1.ax), f_x3(r_s1.px), r_tol);
        ca.v_on = f_near(f_x3(r_s1.px), f_x3(r_s1.la), r_tol);
        ca.v_lt = r_s1.px < r_s1.la;
        ca.zf   = f_near(f_x3(r_s1.la), ZERO_3, r_tol);
        ca.z_on = f_near(f_x3(r_s1.py), f_x3(r_s1.lb), r_tol);
        ca.z_lt = r_s1.py > r_s1.lb;
    end

    logic   m1_v;
    t_coord m1_p;
    t_ca    m1_c;

    pis_mul #(
        .COORD_BITS (C),
        .FRAC_BITS  (F),
        .SIDE_W     ($bits(t_ca))
    ) u_mul_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_v),
        .i_a     (r_s1.la),
        .i_b     (r_s1.px),
        .i_side  (ca),
        .o_valid (m1_v),
        .o_prod  (m1_p),
        .o_side  (m1_c)
    );

    // line residual
    logic                r_s2_v;
    t_ca                 r_s2_c;
    logic signed [C+1:0] r_s2_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_c <= m1_c;
            r_s2_r <= {{2{m1_p[C-1]}}, m1_p} + {{2{m1_c.lb[C-1]}}, m1_c.lb}
                      - {{2{m1_c.py[C-1]}}, m1_c.py};
        end
    end

    t_cb cb;

    always_comb begin
        cb.lv   = r_s2_c.lv;
        cb.la   = r_s2_c.la;
        cb.lim  = r_s2_c.lim;
        cb.t    = r_s2_c.t;
        cb.betw = r_s2_c.betw;
        cb.l2v  = r_s2_c.l2v;
        cb.zf   = r_s2_c.zf;
        if (r_s2_c.lv) begin
            cb.side = r_s2_c.v_on ? SIDE_ON : (r_s2_c.v_lt ? SIDE_LEFT : SIDE_RIGHT);
        end else if (r_s2_c.zf) begin
            cb.side = r_s2_c.z_on ? SIDE_ON : (r_s2_c.z_lt ? SIDE_LEFT : SIDE_RIGHT);
        end else if (f_near({r_s2_r[C+1], r_s2_r}, ZERO_3, r_tol)) begin
            cb.side = SIDE_ON;
        end else begin
            cb.side = r_s2_r[C+1] ? SIDE_LEFT : SIDE_RIGHT;
        end
    end

    // apex-to-point slope
    logic   d1_v;
    t_coord d1_q;
    t_cb    d1_c;

    pis_div #(
        .COORD_BITS (C),
        .FRAC_BITS  (F),
        .SIDE_W     ($bits(t_cb))
    ) u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_num   (r_s2_c.dyn),
        .i_den   (r_s2_c.dxn),
        .i_side  (cb),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_c)
    );

    logic   r_s3_v;
    t_cb    r_s3_b;
    t_coord r_s3_k2a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_b   <= d1_c;
            r_s3_k2a <= d1_c.l2v ? '0 : d1_q;
        end
    end

    t_cc cc;

    always_comb begin
        cc.b   = r_s3_b;
        cc.k2a = r_s3_k2a;
        cc.kz  = f_near(f_x3(r_s3_k2a), ZERO_3, r_tol);
    end

    // product of the two slopes
    logic   m2_v;
    t_coord m2_p;
    t_cc    m2_c;

    pis_mul #(
        .COORD_BITS (C),
        .FRAC_BITS  (F),
        .SIDE_W     ($bits(t_cc))
    ) u_mul_slopes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_a     (r_s3_b.la),
        .i_b     (r_s3_k2a),
        .i_side  (cc),
        .o_valid (m2_v),
        .o_prod  (m2_p),
        .o_side  (m2_c)
    );

    // pick the case and the operands of the tangent division
    t_cd    cd;
    t_wide  n_num, n_den;
    t_coord k_sel, k1, k2;
    logic   left;

    always_comb begin
        k_sel = m2_c.b.lv ? m2_c.k2a : m2_c.b.la;
        left  = m2_c.b.side == SIDE_LEFT;
        k1    = left ? m2_c.b.la : m2_c.k2a;
        k2    = left ? m2_c.k2a : m2_c.b.la;

        n_num    = f_x1(k2) - f_x1(k1);
        n_den    = ONE_1 + f_x1(m2_p);
        cd.kind  = KIND_TANGENT;
        cd.fixed = '0;
        cd.neg   = 1'b0;
        cd.lim   = m2_c.b.lim;
        cd.t     = m2_c.b.t;

        if (m2_c.b.side == SIDE_ON || (m2_c.b.lv && m2_c.b.l2v)) begin
            cd.kind  = KIND_ANGLE;
            cd.fixed = m2_c.b.betw ? '0 : A180;
        end else if ((m2_c.b.lv && m2_c.kz) || (m2_c.b.l2v && m2_c.b.zf)) begin
            cd.kind  = KIND_ANGLE;
            cd.fixed = A90;
        end else if (m2_c.b.lv || m2_c.b.l2v) begin
            // one line vertical: reciprocal of the other slope's magnitude
            n_num  = ONE_1;
            n_den  = k_sel[C-1] ? (~f_x1(k_sel) + 1'b1) : f_x1(k_sel);
            cd.neg = !m2_c.b.betw;
        end else if (f_near(f_x3(m2_p), NEG_ONE, r_tol)) begin
            cd.kind  = KIND_ANGLE;
            cd.fixed = A90;
        end
    end

    logic  r_s4_v;
    t_cd   r_s4_d;
    t_wide r_s4_num, r_s4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_d   <= cd;
            r_s4_num <= n_num;
            r_s4_den <= n_den;
        end
    end

    logic   d2_v;
    t_coord d2_q;
    t_cd    d2_c;

    pis_div #(
        .COORD_BITS (C),
        .FRAC_BITS  (F),
        .SIDE_W     ($bits(t_cd))
    ) u_div_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_num   (r_s4_num),
        .i_den   (r_s4_den),
        .i_side  (r_s4_d),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_c)
    );

    logic   r_s5_v;
    t_cd    r_s5_d;
    t_coord r_s5_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_d <= d2_c;
            if (d2_c.kind == KIND_ANGLE) begin
                r_s5_val <= d2_c.fixed;
            end else if (d2_c.neg) begin
                r_s5_val <= -d2_q;
            end else begin
                r_s5_val <= d2_q;
            end
        end
    end

    // limit decision
    t_res res;
    logic ins_ang, ins_tan;
    logic t_neg, t_pos, v_neg, v_pos;

    always_comb begin
        t_neg   = r_s5_d.t < 0;
        t_pos   = r_s5_d.t > 0;
        v_neg   = r_s5_val < 0;
        v_pos   = r_s5_val > 0;
        ins_ang = $signed({{ANGLE_W{r_s5_val[C-1]}}, r_s5_val})
                  <= $signed({{C{1'b0}}, r_s5_d.lim});
        ins_tan = (t_neg && v_pos) || (t_neg && v_neg && r_s5_d.t > r_s5_val) ||
                  (t_pos && v_pos && r_s5_d.t > r_s5_val);
        res.in_sector = (r_s5_d.kind == KIND_ANGLE) ? ins_ang : ins_tan;
        res.kind      = r_s5_d.kind;
        res.value     = r_s5_val;
    end

    // output register with skid
    logic r_out_v, r_sk_v;
    t_res r_out, r_sk;
    logic push, out_free;

    assign en       = !r_sk_v;
    assign push     = en && r_s5_v;
    assign out_free = !r_out_v || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (out_free) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= push;
            end
        end else if (push) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_sk_v ? r_sk : res;
        end else if (push) begin
            r_sk <= res;
        end
    end

    assign o_result.valid        = r_out_v;
    assign o_result.in_sector    = r_out.in_sector;
    assign o_result.result_kind  = r_out.kind;
    assign o_result.result_value = r_out.value;

`ifndef SYNTH
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("skid holds an item while the output register is empty");

    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_v) |-> $past(r_out_v && !o_result.ready))
        else $error("skid filled although the output item was taken");

    a_freeze : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |=> r_s5_v == $past(r_s5_v) && r_s1_v == $past(r_s1_v))
        else $error("pipeline moved while frozen");

    a_angle_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.kind == KIND_ANGLE) |->
            (r_out.value == '0 || r_out.value == A90 || r_out.value == A180))
        else $error("angle result is not one of the fixed angles");
`endif

endmodule

>>> verif/point_in_sector_test_tb.sv
module point_in_sector_test_tb;
    import pis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 2 * CB + 18;
    localparam longint ONE_Q = 64'sd1 <<< FB;
    localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint CMIN = -(64'sd1 <<< (CB - 1));

    typedef enum logic [1:0] {SIDE_ON, SIDE_LEFT, SIDE_RIGHT} side_e;

    typedef struct packed {
        logic                 vert;
        logic signed [CB-1:0] slope, icpt, ax, ay, dx, dy, px, py;
        logic [ANGLE_W-1:0]   lim_ang;
        logic signed [CB-1:0] lim_tan;
    } query_t;

    typedef struct packed {
        logic                 in_sector;
        logic                 kind;
        logic signed [CB-1:0] value;
    } verdict_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pis_cfg_if                  cfg_ch ();
    pis_item_if   #(.COORD_BITS(CB)) item_ch ();
    pis_result_if #(.COORD_BITS(CB)) res_ch ();

    point_in_sector_test #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_item  (item_ch.sink),
        .o_result(res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    verdict_t    pending_verdicts[$];
    longint      tol = 1;
    int          errors = 0;
    int          n_items = 0;
    int          n_checked = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;

    initial begin
        #50ms;
        $display("point_in_sector_test_tb NOT OK");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint absq(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint satq(longint v);
        return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
    endfunction

    function automatic bit near(longint a, longint b);
        return absq(a - b) <= tol;
    endfunction

    // truncated magnitude product, saturated
    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        p = (128'(absq(a)) * 128'(absq(b))) >> FB;
        if (p > 128'(CMAX) + 1) return ((a < 0) != (b < 0)) ? CMIN : CMAX;
        return satq(((a < 0) != (b < 0)) ? -longint'(p) : longint'(p));
    endfunction

    function automatic longint qdiv(longint num, longint den);
        logic [127:0] q;
        if (den == 0) return 0;
        q = (128'(absq(num)) << FB) / 128'(absq(den));
        if (q > 128'(CMAX) + 1) return ((num < 0) != (den < 0)) ? CMIN : CMAX;
        return satq(((num < 0) != (den < 0)) ? -longint'(q) : longint'(q));
    endfunction

    function automatic side_e line_side(bit v, longint a, longint b, longint x, longint y);
        longint r;
        if (v) begin
            if (near(x, a)) return SIDE_ON;
            return x < a ? SIDE_LEFT : SIDE_RIGHT;
        end
        if (near(a, 0)) begin
            if (near(y, b)) return SIDE_ON;
            return y > b ? SIDE_LEFT : SIDE_RIGHT;
        end
        r = qmul(a, x) + b - y;
        if (near(r, 0)) return SIDE_ON;
        return r < 0 ? SIDE_LEFT : SIDE_RIGHT;
    endfunction

    function automatic bit faces_dir(longint sx, longint sy, longint rx, longint ry,
                                     longint px, longint py);
        bit xl, yl, xp, yp;
        xl = rx - sx < 0;
        yl = ry - sy < 0;
        xp = px - sx < 0;
        yp = py - sy < 0;
        if (near(px, sx) || near(px, rx)) xp = (yl == yp) ? xl : !xl;
        if (near(py, sy) || near(py, ry)) yp = (xl == xp) ? yl : !yl;
        return (xl == xp) || (yl == yp);
    endfunction

    function automatic verdict_t classify(query_t q);
        verdict_t vd;
        side_e    sd;
        bit       betw, tkind, apex_vert;
        longint   la, k2a, v, k, t, k1, k2, qq;
        la = q.slope;
        sd = line_side(q.vert, la, q.icpt, q.px, q.py);
        betw = faces_dir(q.ax, q.ay, q.dx, q.dy, q.px, q.py);
        apex_vert = near(q.ax, q.px);
        k2a = 0;
        tkind = 0;
        if (!apex_vert) k2a = qdiv(longint'(q.py) - q.ay, longint'(q.px) - q.ax);
        if (sd == SIDE_ON || (q.vert && apex_vert)) begin
            v = betw ? 0 : 180 * ONE_Q;
        end else if ((q.vert && near(k2a, 0)) || (apex_vert && near(la, 0))) begin
            v = 90 * ONE_Q;
        end else if (q.vert || apex_vert) begin
            k = q.vert ? k2a : la;
            qq = qdiv(ONE_Q, absq(k));
            v = betw ? qq : -qq;
            tkind = 1;
        end else if (near(qmul(la, k2a), -ONE_Q)) begin
            v = 90 * ONE_Q;
        end else begin
            k1 = (sd == SIDE_LEFT) ? la : k2a;
            k2 = (sd == SIDE_LEFT) ? k2a : la;
            v = qdiv(k2 - k1, ONE_Q + qmul(k1, k2));
            tkind = 1;
        end
        v = satq(v);
        t = q.lim_tan;
        if (!tkind) vd.in_sector = v <= longint'(q.lim_ang);
        else vd.in_sector = (t < 0 && v > 0) || (t < 0 && v < 0 && t > v) ||
                            (t > 0 && v > 0 && t > v);
        vd.kind = tkind;
        vd.value = v[CB-1:0];
        return vd;
    endfunction

    // ---------------- drivers ----------------
    initial begin
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        item_ch.valid = 0;
        {item_ch.line_vertical, item_ch.line_slope, item_ch.line_intercept,
         item_ch.apex_x, item_ch.apex_y, item_ch.dir_x, item_ch.dir_y,
         item_ch.point_x, item_ch.point_y, item_ch.limit_angle,
         item_ch.limit_tangent} = '0;
        res_ch.ready = 0;
    end

    task automatic send_item(query_t q);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.line_vertical  <= q.vert;
        item_ch.line_slope     <= q.slope;
        item_ch.line_intercept <= q.icpt;
        item_ch.apex_x         <= q.ax;
        item_ch.apex_y         <= q.ay;
        item_ch.dir_x          <= q.dx;
        item_ch.dir_y          <= q.dy;
        item_ch.point_x        <= q.px;
        item_ch.point_y        <= q.py;
        item_ch.limit_angle    <= q.lim_ang;
        item_ch.limit_tangent  <= q.lim_tan;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        pending_verdicts.push_back(classify(q));
        n_items++;
    endtask

    task automatic drop_valid();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        int guard;
        drop_valid();
        guard = 0;
        while (pending_verdicts.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("point_in_sector_test_tb NOT OK");
            $finish;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        tol = val;
        @(posedge i_clk);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= i_rst_n &&
                !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        verdict_t exp_v;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result %0b %0b %h", $time,
                         res_ch.in_sector, res_ch.result_kind, res_ch.result_value);
                errors++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                n_checked++;
                if (exp_v.in_sector !== res_ch.in_sector ||
                    exp_v.kind !== res_ch.result_kind ||
                    exp_v.value !== res_ch.result_value) begin
                    $display("%0t: mismatch exp in=%0b kind=%0b val=%h got in=%0b kind=%0b val=%h",
                             $time, exp_v.in_sector, exp_v.kind, exp_v.value,
                             res_ch.in_sector, res_ch.result_kind, res_ch.result_value);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return CB'($signed($urandom_range(0, 40)) - 20) <<< FB;
            2: return $urandom_range(0, 3) == 0 ? CB'(CMAX) : CB'(CMIN);
            default: return CB'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        q.vert = $urandom_range(0, 4) == 0;
        q.slope = rand_coord();
        q.icpt = rand_coord();
        q.ax = rand_coord();
        q.ay = rand_coord();
        q.dx = rand_coord();
        q.dy = rand_coord();
        q.px = rand_coord();
        q.py = rand_coord();
        // steer into special cases now and then
        case ($urandom_range(0, 9))
            0: q.px = q.ax + CB'($signed($urandom_range(0, 4)) - 2);
            1: q.slope = CB'($signed($urandom_range(0, 4)) - 2);
            2: if (!q.vert) q.py = CB'(qmul(q.slope, q.px) + q.icpt);
            3: q.px = q.dx;
            4: q.py = q.ay;
            default: ;
        endcase
        q.lim_ang = $urandom_range(0, 3) == 0 ? ANGLE_W'($urandom()) :
                    ANGLE_W'($urandom_range(0, 180) << FB);
        q.lim_tan = $urandom_range(0, 3) == 0 ? $urandom() : rand_coord();
        return q;
    endfunction

    task automatic test_directed();
        query_t q;
        q = '0;
        send_item(q);                       // all zero: point on line
        q.vert = 1; q.slope = 5 << FB; q.px = 5 << FB; q.py = 1 << FB;
        send_item(q);                       // on vertical line
        q.px = q.ax;                        // both vertical
        q.ax = 1 << FB; q.px = 1 << FB; q.py = 3 << FB; q.dy = 2 << FB;
        send_item(q);
        q.vert = 0; q.slope = 0; q.icpt = 7 << FB;
        send_item(q);                       // perpendicular: apex line vertical, flat line
        q.slope = 2 << FB; q.icpt = 0;
        q.ax = 0; q.ay = 0; q.px = 4 << FB; q.py = -(2 << FB); q.dx = 1 << FB; q.dy = 0;
        send_item(q);                       // perpendicular by slope product
        q.vert = 1; q.slope = -(9 << FB); q.py = 3 << FB; q.lim_tan = -1;
        send_item(q);                       // one vertical, tangent
        q.vert = 0; q.slope = 1 << FB; q.icpt = 3 << FB; q.py = 1 << FB;
        q.lim_tan = 1 << FB; q.lim_ang = '1;
        send_item(q);                       // general tangent
        q.slope = CB'(CMAX); q.icpt = CB'(CMIN); q.ax = CB'(CMIN); q.ay = CB'(CMAX);
        q.dx = CB'(CMAX); q.dy = CB'(CMIN); q.px = CB'(CMAX); q.py = CB'(CMIN);
        q.lim_tan = CB'(CMIN);
        send_item(q);                       // saturation extremes
        q = '1;
        send_item(q);
        q.vert = 0; q.lim_ang = 180 << FB; q.lim_tan = CB'(CMAX);
        send_item(q);
        q.slope = 1; q.px = 3; q.ax = 0; q.py = 1 <<< 30; q.ay = 0;
        send_item(q);                       // tiny denominator, saturated quotient
        repeat (10) send_item(rand_query());
        drain_pipe();
    endtask

    task automatic test_random(int count);
        repeat (count) send_item(rand_query());
    endtask

    task automatic test_backpressure();
        fork
            hold_cycles = 300;
            repeat (250) send_item(rand_query());
        join
        drain_pipe();
    endtask

    task automatic test_tolerances();
        logic [TOL_W-1:0] settings[4];
        settings = '{16'd0, 16'hFFFF, 16'd37, TOL_RESET};
        foreach (settings[i]) begin
            write_tolerance(settings[i]);
            test_random(150);
            drain_pipe();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 8;  recv_idle_pct = 64;
        test_random(400);
        drain_pipe();
        send_idle_pct = 64; recv_idle_pct = 8;
        test_random(400);
        drain_pipe();
        send_idle_pct = 0;  recv_idle_pct = 0;
        test_random(300);
        drain_pipe();
        test_backpressure();
        test_tolerances();
        $display("covered %0d items, %0d results checked, tolerance at 0, 1, 37 and max,",
                 n_items, n_checked);
        $display("with idling on both sides and a long output stall");
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("point_in_sector_test_tb OK");
        end else begin
            $display("point_in_sector_test_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
design/pis_pkg.sv
design/pis_if.sv
design/pis_mul.sv
design/pis_div.sv
design/point_in_sector_test.sv
verif/point_in_sector_test_tb.sv
